>>> src/frm_pkg.sv
// shared types and constants of the frame rate meter
`default_nettype none

package frm_pkg;

   // field widths
   localparam int unsigned CMD_W    = 2;
   localparam int unsigned TS_W     = 32;
   localparam int unsigned RATE_W   = 16;
   localparam int unsigned TARGET_W = 10;
   localparam int unsigned TICK_W   = 16;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned REQ_DATA_W = 32;
   localparam int unsigned RSP_DATA_W = 80;

   // divisor width of the shared divider
   localparam int unsigned DIV_W = 32;

   // command codes
   localparam logic [CMD_W-1:0] CMD_START = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FRAME = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_RATE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TICK_RATE   = 1'd1;

   // register reset values
   localparam logic [TARGET_W-1:0] TARGET_RESET = 10'd60;
   localparam logic [TICK_W-1:0]   TICK_RESET   = 16'd1000;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] divisor;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

`default_nettype wire

>>> src/frm_div.sv
// serial restoring divider, one quotient bit per cycle
`default_nettype none

module frm_div #(
   parameter int unsigned DIVIDEND_W = 20
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire frm_pkg::div_ctl_type     ctl,
   input  wire logic [DIVIDEND_W-1:0]    dividend,
   output frm_pkg::div_stat_type         stat,
   output logic [DIVIDEND_W-1:0]         quotient
);
   import frm_pkg::*;

   localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] qr_ff, qr_in;
   logic [DIV_W-1:0]      rem_ff, rem_in;
   logic [DIV_W-1:0]      dvs_ff, dvs_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [DIV_W:0] shifted;
   logic [DIV_W:0] diff;
   logic           take;

   always_comb begin
      shifted = {rem_ff, qr_ff[DIVIDEND_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      take    = ~diff[DIV_W];

      qr_in   = qr_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (ctl.start) begin
         qr_in   = dividend;
         rem_in  = '0;
         dvs_in  = ctl.divisor;
         cnt_in  = CNT_W'(DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         rem_in = take ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
         qr_in  = {qr_ff[DIVIDEND_W-2:0], take};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      qr_ff  <= qr_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = qr_ff;

endmodule

`default_nettype wire

>>> src/frame_rate_meter.sv
// top level of the frame rate meter: sequencer, history memory and result register
`default_nettype none

// Frame rate meter. Each request carries a command in req_tuser and a
// free-running 32-bit tick timestamp in req_tdata, and produces exactly one
// response. A start command sets both frame times to the timestamp and clears
// the current rate; a new-frame command measures the ticks since the last
// frame, divides tick_rate by them (0 for a zero interval) and pushes that rate
// into a history of the last HISTORY_DEPTH rates whose integer mean is
// reported; a query (and the unused code 3) changes nothing. Every response
// also gives the ticks left until the next frame is due at target_rate,
// clamped at zero. All divisions run one after another on a single serial
// divider that yields one quotient bit per cycle over W = 16 +
// clog2(HISTORY_DEPTH) bits; a new-frame request runs up to three divisions
// (rate, interval, average), a start or query up to two, and req_tready stays
// low meanwhile. The response sits in an output register, so the next
// request is taken while it waits on rsp_tready. Registers must be written
// through csr_we / csr_index / csr_wdata only while no request is in flight;
// the block does not enforce this. A target rate of zero counts as one.

module frame_rate_meter #(
   parameter int unsigned HISTORY_DEPTH = 10
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [frm_pkg::REQ_DATA_W-1:0]    req_tdata,  // [31:0] timestamp
   input  wire logic [frm_pkg::CMD_W-1:0]         req_tuser,  // [1:0] command
   // response channel
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [15:0] current_rate, [31:16] average_rate, [63:32] elapsed_ticks,
   // [79:64] time_till_next
   output logic [frm_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   // register write port
   input  wire logic                              csr_we,
   input  wire logic [frm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [frm_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import frm_pkg::*;

   // history sizing
   localparam int unsigned SUM_W = RATE_W + $clog2(HISTORY_DEPTH);
   localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam int unsigned PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

   // sequencer states
   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_RATE_GO   = 4'd1;
   localparam logic [3:0] S_RATE_WAIT = 4'd2;
   localparam logic [3:0] S_HREAD     = 4'd3;
   localparam logic [3:0] S_HPUSH     = 4'd4;
   localparam logic [3:0] S_INTV_GO   = 4'd5;
   localparam logic [3:0] S_INTV_WAIT = 4'd6;
   localparam logic [3:0] S_AVG_GO    = 4'd7;
   localparam logic [3:0] S_AVG_WAIT  = 4'd8;
   localparam logic [3:0] S_DONE      = 4'd9;

   logic [3:0]          state_ff, state_in;
   logic [TARGET_W-1:0] target_ff, target_in;
   logic [TICK_W-1:0]   tick_ff, tick_in;
   logic [TS_W-1:0]     prev_ff, prev_in;
   logic [TS_W-1:0]     frame_ff, frame_in;
   logic [TS_W-1:0]     ts_ff, ts_in;
   logic [RATE_W-1:0]   latest_ff, latest_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [PTR_W-1:0]    ptr_ff, ptr_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [RATE_W-1:0]   interval_ff, interval_in;
   logic [RATE_W-1:0]   avg_ff, avg_in;
   logic [RATE_W-1:0]   hist_rd_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // rate history memory, written once per new frame
   logic [RATE_W-1:0] hist_mem [HISTORY_DEPTH];

   div_ctl_type       div_ctl;
   div_stat_type      div_stat;
   logic [SUM_W-1:0]  div_dividend;
   logic [SUM_W-1:0]  div_quotient;

   logic              req_accept;
   logic              out_free;
   logic              hist_full;
   logic [TS_W-1:0]   delta_now;
   logic [TS_W-1:0]   since;
   logic [RATE_W-1:0] left;
   logic [TS_W-1:0]   elapsed;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign hist_full  = (count_ff >= CNT_W'(HISTORY_DEPTH));
   assign delta_now  = req_tdata[TS_W-1:0] - frame_ff;

   // ticks left until the next frame, clamped at zero
   assign since   = ts_ff - frame_ff;
   assign elapsed = frame_ff - prev_ff;
   assign left    = (since >= TS_W'(interval_ff)) ? '0 : (interval_ff - since[RATE_W-1:0]);

   // operand selection for the shared divider
   always_comb begin
      div_ctl.start   = 1'b0;
      div_ctl.divisor = DIV_W'(1);
      div_dividend    = SUM_W'(tick_ff);
      unique case (state_ff)
         S_RATE_GO: begin
            div_ctl.start   = 1'b1;
            div_ctl.divisor = elapsed;
         end
         S_INTV_GO: begin
            div_ctl.start   = 1'b1;
            div_ctl.divisor = (target_ff == '0) ? DIV_W'(1) : DIV_W'(target_ff);
         end
         S_AVG_GO: begin
            div_ctl.start   = (count_ff != '0);
            div_ctl.divisor = DIV_W'(count_ff);
            div_dividend    = sum_ff;
         end
         default: begin
            div_ctl.start = 1'b0;
         end
      endcase
   end

   frm_div #(
      .DIVIDEND_W (SUM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (div_dividend),
      .stat     (div_stat),
      .quotient (div_quotient)
   );

   // sequencer and state update
   always_comb begin
      state_in     = state_ff;
      target_in    = target_ff;
      tick_in      = tick_ff;
      prev_in      = prev_ff;
      frame_in     = frame_ff;
      ts_in        = ts_ff;
      latest_in    = latest_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      sum_in       = sum_ff;
      interval_in  = interval_ff;
      avg_in       = avg_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;

      // register writes, to be made only while idle; the block does not enforce it
      if (csr_we) begin
         unique case (csr_index)
            REG_TARGET_RATE: target_in = csr_wdata[TARGET_W-1:0];
            REG_TICK_RATE:   tick_in   = csr_wdata[TICK_W-1:0];
            default:         target_in = target_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               ts_in = req_tdata[TS_W-1:0];
               priority if (req_tuser == CMD_START) begin
                  prev_in   = req_tdata[TS_W-1:0];
                  frame_in  = req_tdata[TS_W-1:0];
                  latest_in = '0;
                  state_in  = S_INTV_GO;
               end else if (req_tuser == CMD_FRAME) begin
                  prev_in  = frame_ff;
                  frame_in = req_tdata[TS_W-1:0];
                  // a zero interval skips the division and records rate zero
                  if (delta_now == '0) begin
                     latest_in = '0;
                     state_in  = S_HREAD;
                  end else begin
                     state_in = S_RATE_GO;
                  end
               end else begin
                  // query and the unused code leave the state alone
                  state_in = S_INTV_GO;
               end
            end
         end
         S_RATE_GO: begin
            state_in = S_RATE_WAIT;
         end
         S_RATE_WAIT: begin
            if (div_stat.done) begin
               latest_in = div_quotient[RATE_W-1:0];
               state_in  = S_HREAD;
            end
         end
         S_HREAD: begin
            // memory read of the slot about to be replaced
            state_in = S_HPUSH;
         end
         S_HPUSH: begin
            if (hist_full) begin
               sum_in = sum_ff - SUM_W'(hist_rd_ff) + SUM_W'(latest_ff);
            end else begin
               sum_in   = sum_ff + SUM_W'(latest_ff);
               count_in = count_ff + CNT_W'(1);
            end
            ptr_in   = (ptr_ff == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : ptr_ff + PTR_W'(1);
            state_in = S_INTV_GO;
         end
         S_INTV_GO: begin
            state_in = S_INTV_WAIT;
         end
         S_INTV_WAIT: begin
            if (div_stat.done) begin
               interval_in = div_quotient[RATE_W-1:0];
               state_in    = S_AVG_GO;
            end
         end
         S_AVG_GO: begin
            if (count_ff == '0) begin
               avg_in   = '0;
               state_in = S_DONE;
            end else begin
               state_in = S_AVG_WAIT;
            end
         end
         S_AVG_WAIT: begin
            if (div_stat.done) begin
               avg_in   = div_quotient[RATE_W-1:0];
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // wait here until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {left, elapsed, avg_ff, latest_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         target_ff    <= TARGET_RESET;
         tick_ff      <= TICK_RESET;
         prev_ff      <= '0;
         frame_ff     <= '0;
         latest_ff    <= '0;
         count_ff     <= '0;
         ptr_ff       <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         target_ff    <= target_in;
         tick_ff      <= tick_in;
         prev_ff      <= prev_in;
         frame_ff     <= frame_in;
         latest_ff    <= latest_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ts_ff       <= ts_in;
      interval_ff <= interval_in;
      avg_ff      <= avg_in;
      rsp_data_ff <= rsp_data_in;
   end

   // history memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (state_ff == S_HPUSH) begin
         hist_mem[ptr_ff] <= latest_ff;
      end
      hist_rd_ff <= hist_mem[ptr_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // the history never holds more entries than it has slots
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(HISTORY_DEPTH))
      else $error("history count beyond depth");

   // a new response only comes out of the final state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff == S_DONE))
      else $error("response raised outside final state");

   // the divider is never restarted while it is working
   a_div_no_restart: assert property (@(posedge clock) disable iff (reset)
      div_ctl.start |-> !div_stat.busy)
      else $error("divider started while busy");

   // a divider result arrives only while the sequencer waits for it
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == S_RATE_WAIT || state_ff == S_INTV_WAIT ||
                         state_ff == S_AVG_WAIT))
      else $error("divider result with nobody waiting");
`endif

endmodule

`default_nettype wire

>>> test/frame_rate_meter_tb.sv
// testbench of the frame rate meter: random and directed requests checked by a scoreboard
`timescale 1ns / 1ps

class rate_scoreboard #(int unsigned DEPTH = 10);

   typedef struct packed {
      logic [15:0] time_till_next;
      logic [31:0] elapsed_ticks;
      logic [15:0] average_rate;
      logic [15:0] current_rate;
   } frame_report_type;

   logic [frm_pkg::TARGET_W-1:0] target_rate;
   logic [frm_pkg::TICK_W-1:0]   tick_rate;
   logic [31:0]                  prev_time;
   logic [31:0]                  frame_time;
   logic [15:0]                  last_rate;
   logic [15:0]                  history [DEPTH];
   int unsigned                  hist_count;
   int unsigned                  hist_slot;
   logic [19:0]                  hist_sum;
   frame_report_type             pending_reports [$];
   int unsigned                  mismatches;

   function new();
      target_rate = frm_pkg::TARGET_RESET;
      tick_rate   = frm_pkg::TICK_RESET;
      prev_time   = '0;
      frame_time  = '0;
      last_rate   = '0;
      hist_count  = 0;
      hist_slot   = 0;
      hist_sum    = '0;
      mismatches  = 0;
   endfunction

   function void set_rates(logic [frm_pkg::TARGET_W-1:0] target, logic [frm_pkg::TICK_W-1:0] tick);
      target_rate = target;
      tick_rate   = tick;
   endfunction

   function int unsigned outstanding();
      return pending_reports.size();
   endfunction

   // compute the report that one accepted request must produce
   function void note_request(logic [frm_pkg::CMD_W-1:0] cmd, logic [31:0] stamp);
      frame_report_type exp;
      logic [31:0] delta;
      logic [31:0] since;
      logic [31:0] interval;
      logic [31:0] divisor;
      if (cmd == frm_pkg::CMD_START) begin
         prev_time  = stamp;
         frame_time = stamp;
         last_rate  = '0;
      end else if (cmd == frm_pkg::CMD_FRAME) begin
         prev_time  = frame_time;
         frame_time = stamp;
         delta      = frame_time - prev_time;
         last_rate  = (delta == 0) ? 16'd0 : 16'({16'd0, tick_rate} / delta);
         // full history: drop the oldest rate from the sum
         if (hist_count >= DEPTH) begin
            hist_sum = hist_sum - 20'(history[hist_slot]);
         end else begin
            hist_count++;
         end
         history[hist_slot] = last_rate;
         hist_sum  = hist_sum + 20'(last_rate);
         hist_slot = (hist_slot + 1 == DEPTH) ? 0 : hist_slot + 1;
      end
      divisor  = (target_rate == 0) ? 32'd1 : 32'(target_rate);
      interval = 32'(tick_rate) / divisor;
      since    = stamp - frame_time;
      exp.current_rate   = last_rate;
      exp.average_rate   = (hist_count == 0) ? 16'd0 : 16'(32'(hist_sum) / hist_count);
      exp.elapsed_ticks  = frame_time - prev_time;
      exp.time_till_next = (since >= interval) ? 16'd0 : 16'(interval - since);
      pending_reports.insert(pending_reports.size(), exp);
   endfunction

   function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
         mismatches++;
         $display("%0t %s mismatch: expected %0d actual %0d", $time, name, exp, act);
      end
   endfunction

   function void check_response(logic [frm_pkg::RSP_DATA_W-1:0] data);
      frame_report_type got;
      frame_report_type exp;
      got = data;
      if (pending_reports.size() == 0) begin
         mismatches++;
         $display("%0t response with no request outstanding: expected none actual %h",
                  $time, data);
      end else begin
         exp = pending_reports[0];
         pending_reports.delete(0);
         compare_field("current_rate", 32'(exp.current_rate), 32'(got.current_rate));
         compare_field("average_rate", 32'(exp.average_rate), 32'(got.average_rate));
         compare_field("elapsed_ticks", exp.elapsed_ticks, got.elapsed_ticks);
         compare_field("time_till_next", 32'(exp.time_till_next), 32'(got.time_till_next));
      end
   endfunction

endclass

module frame_rate_meter_tb;

   localparam int unsigned HIST_DEPTH  = 10;
   // cycles to let pass after the last response before touching registers or ending
   localparam int unsigned DRAIN_WAIT  = 100;
   // cycles without any handshake before the run is declared hung
   localparam int unsigned STALL_LIMIT = 4000;
   // unused command code, behaves as a query
   localparam logic [frm_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [frm_pkg::REQ_DATA_W-1:0]  req_tdata;
   logic [frm_pkg::CMD_W-1:0]       req_tuser;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [frm_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic                            csr_we;
   logic [frm_pkg::CSR_IDX_W-1:0]   csr_index;
   logic [frm_pkg::CSR_DATA_W-1:0]  csr_wdata;

   rate_scoreboard #(HIST_DEPTH) board;

   // idle chances in percent per cycle, set per phase
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   // long receiver hold-off, counted down by the receiver process
   int unsigned rsp_hold_left;
   // running timestamp of the random part
   logic [31:0] stamp_now;

   frame_rate_meter #(
      .HISTORY_DEPTH(HIST_DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [31:0] timestamp
      .req_tuser  (req_tuser),   // [1:0] command
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      // [15:0] current_rate, [31:16] average_rate, [63:32] elapsed_ticks,
      // [79:64] time_till_next
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // receiver: decides rsp_tready at each falling edge
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            // long hold-off so the block fills up and stalls its input
            rsp_tready <= 1'b0;
            rsp_hold_left = rsp_hold_left - 1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // response monitor: every accepted response goes to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_response(rsp_tdata);
      end
   end

   // watchdog: ends the run if no handshake happens for too long
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("status: fail");
      $finish;
   end

   // offer one request; called and returns at a falling edge
   task automatic send_request(logic [frm_pkg::CMD_W-1:0] cmd, logic [31:0] stamp);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do begin
            @(negedge clock);
         end while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= stamp;
      do begin
         @(posedge clock);
      end while (!req_tready);
      board.note_request(cmd, stamp);
      @(negedge clock);
   endtask

   // stop offering, wait for all responses, then let the block go quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (board.outstanding() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   // write both registers back to back, raw values get masked by the block
   task automatic program_rates(logic [15:0] target_raw, logic [15:0] tick_raw);
      csr_we    <= 1'b1;
      csr_index <= frm_pkg::REG_TARGET_RATE;
      csr_wdata <= target_raw;
      @(negedge clock);
      csr_index <= frm_pkg::REG_TICK_RATE;
      csr_wdata <= tick_raw;
      @(negedge clock);
      csr_we    <= 1'b0;
      board.set_rates(target_raw[frm_pkg::TARGET_W-1:0], tick_raw);
      @(negedge clock);
   endtask

   // mostly start-then-frames sequences with random spacing, some noise
   task automatic run_random(int unsigned n_items);
      int unsigned sent;
      int unsigned seq_len;
      int unsigned span;
      logic [31:0] step;
      logic [frm_pkg::CMD_W-1:0] cmd;
      sent = 0;
      span = 32'(board.tick_rate) / ((board.target_rate == 0) ? 32'd1 : 32'(board.target_rate));
      while (sent < n_items) begin
         if ($urandom_range(0, 99) < 85) begin
            case ($urandom_range(0, 3))
               0: stamp_now = $urandom;
               1: stamp_now = 32'hFFFF_FFFF - $urandom_range(0, 64);   // wrap soon
               default: stamp_now = stamp_now + $urandom_range(0, 1000);
            endcase
            send_request(frm_pkg::CMD_START, stamp_now);
            sent++;
            seq_len = $urandom_range(3, 24);
            repeat (seq_len) begin
               case ($urandom_range(0, 9))
                  0: step = '0;
                  1: step = $urandom;
                  2: step = $urandom_range(1, 4);
                  default: step = $urandom_range(0, 2 * span + 2);
               endcase
               stamp_now = stamp_now + step;
               if ($urandom_range(0, 99) < 65) begin
                  cmd = frm_pkg::CMD_FRAME;
               end else if ($urandom_range(0, 9) == 0) begin
                  cmd = CMD_SPARE;
               end else begin
                  cmd = frm_pkg::CMD_QUERY;
               end
               send_request(cmd, stamp_now);
               sent++;
            end
         end else begin
            // noise: any command at any timestamp
            send_request(frm_pkg::CMD_W'($urandom_range(0, 3)), $urandom);
            sent++;
         end
      end
   endtask

   // one phase: drain, reprogram, set idling, optional hold-off, random traffic
   task automatic run_phase(logic [15:0] target_raw, logic [15:0] tick_raw,
                            int unsigned send_pct, int unsigned recv_pct,
                            int unsigned hold_len, int unsigned n_items);
      settle();
      program_rates(target_raw, tick_raw);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      rsp_hold_left = hold_len;
      run_random(n_items);
   endtask

   initial begin : main_flow
      logic [31:0] stamp;
      board         = new();
      send_idle_pct = 30;
      recv_idle_pct = 47;
      rsp_hold_left = 0;
      stamp_now     = '0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = frm_pkg::CMD_START;
      csr_we        = 1'b0;
      csr_index     = frm_pkg::REG_TARGET_RATE;
      csr_wdata     = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part at the reset register values (interval 16 ticks)
      send_request(frm_pkg::CMD_QUERY, 32'd0);           // query on fresh state
      send_request(frm_pkg::CMD_FRAME, 32'd0);           // zero interval gives rate 0
      send_request(frm_pkg::CMD_FRAME, 32'd1);           // one tick, rate = tick_rate
      send_request(frm_pkg::CMD_QUERY, 32'd5);
      send_request(CMD_SPARE, 32'd100);                  // spare code, clamped at zero
      send_request(frm_pkg::CMD_START, 32'hFFFF_FFF0);   // start keeps the history
      send_request(frm_pkg::CMD_FRAME, 32'h0000_0010);   // interval across the wrap
      send_request(frm_pkg::CMD_FRAME, 32'hFFFF_FFFF);   // huge interval, rate 0
      stamp = 32'hFFFF_FFFF;
      // fill the history and roll over its oldest entries
      for (int i = 0; i < 12; i++) begin
         stamp = stamp + 32'(3 + i);
         send_request(frm_pkg::CMD_FRAME, stamp);
      end
      send_request(frm_pkg::CMD_START, 32'h1234_5678);
      send_request(frm_pkg::CMD_QUERY, 32'h1234_5677);   // timestamp before frame time
      send_request(frm_pkg::CMD_FRAME, 32'h1234_5688);
      send_request(frm_pkg::CMD_QUERY, 32'h1234_5698);

      // random phases: receiver idles more, then sender, then neither
      run_phase(16'd60,    16'd1000,  30, 47, 0,   115);
      run_phase(16'd1000,  16'd65535, 30, 47, 600, 115);  // extremes, long hold-off
      run_phase(16'hFC00,  16'd5000,  47, 30, 0,   115);  // target masks to zero
      run_phase(16'd1,     16'd0,     47, 30, 0,   115);  // zero tick rate
      run_phase(16'd1,     16'd1,     0,  0,  0,   115);  // lowest rates
      run_phase(16'hFFFF,  16'd30000, 0,  0,  0,   115);  // all target bits set
      run_phase(16'd7,     16'd250,   0,  0,  0,   115);

      settle();
      if (board.mismatches == 0 && board.outstanding() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
